[sv/bblur_pkg.sv]
// Shared types, constants and helpers for the 3x3 box blur.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package bblur_pkg;

	localparam int MAX_LINE_PIXELS_DEF = 1024;

	localparam int FRAME_W_BITS = 11;
	localparam int FRAME_H_BITS = 12;
	localparam int CH_BITS      = 8;
	localparam int PIX_BITS     = 3 * CH_BITS;

	// nine samples of 8 bits plus the rounding half
	localparam int SUM_W   = 12;
	localparam int CNT_W   = 4;
	localparam int RECIP_K = 16;
	localparam int RECIP_W = RECIP_K + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// neighbour offset codes along a row or a column
	localparam logic [1:0] SEL_BEFORE = 2'd0;
	localparam logic [1:0] SEL_CENTRE = 2'd1;
	localparam logic [1:0] SEL_AFTER  = 2'd2;

	typedef struct packed {
		logic       store;
		logic       start;
		logic       rd;
		logic [1:0] row_sel;
		logic [1:0] col_sel;
		logic       divide;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic res_ready;
		logic out_free;
	} sts_t;

	// ceil(2^16 / n); exact floor division for sums below 2300
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		unique case (n)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/bblur_if.sv]
// Valid/ready channel interfaces for pixels in and blurred results out.
// Depends on bblur_pkg for the channel width.
`default_nettype none

interface bblur_in_if;
	import bblur_pkg::*;
	logic               valid;
	logic               ready;
	logic               func;
	logic [CH_BITS-1:0] in_red;
	logic [CH_BITS-1:0] in_green;
	logic [CH_BITS-1:0] in_blue;

	modport source (output valid, func, in_red, in_green, in_blue, input ready);
	modport sink   (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

interface bblur_out_if;
	import bblur_pkg::*;
	logic               valid;
	logic               ready;
	logic [CH_BITS-1:0] out_red;
	logic [CH_BITS-1:0] out_green;
	logic [CH_BITS-1:0] out_blue;
	logic               frame_end;

	modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

[sv/bblur_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module bblur_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2057
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/bblur_ctrl.sv]
// Controller: takes an item and, if a result is ready, steps the nine neighbour
// reads, then divides and hands the result over. Depends on bblur_pkg.
`default_nettype none

module bblur_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_ready,
	output bblur_pkg::cmd_t cmd,
	input  bblur_pkg::sts_t sts
);

	import bblur_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_READ   = 6'b000100,
		ST_FLUSH  = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] row_q, row_d;
	logic [1:0] col_q, col_d;

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		cmd       = '0;
		pix_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pix_ready = 1'b1;
				if (pix_valid) begin
					cmd.store = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.res_ready) begin
					cmd.start = 1'b1;
					row_d     = SEL_BEFORE;
					col_d     = SEL_BEFORE;
					state_d   = ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd      = 1'b1;
				cmd.row_sel = row_q;
				cmd.col_sel = col_q;
				if (col_q == SEL_AFTER) begin
					col_d = SEL_BEFORE;
					if (row_q == SEL_AFTER) begin
						state_d = ST_FLUSH;
					end else begin
						row_d = row_q + 2'd1;
					end
				end else begin
					col_d = col_q + 2'd1;
				end
			end
			// last read data lands in the accumulator
			ST_FLUSH: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.divide = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= SEL_BEFORE;
			col_q   <= SEL_BEFORE;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

endmodule

`default_nettype wire

[sv/bblur_dp.sv]
// Datapath: pixel history ring in RAM, frame position, neighbour addressing,
// accumulation, reciprocal division and the output register. Depends on bblur_pkg, bblur_ram.
`default_nettype none

module bblur_dp #(
	parameter int MAX_LINE_PIXELS = bblur_pkg::MAX_LINE_PIXELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bblur_pkg::cmd_t                      cmd,
	output bblur_pkg::sts_t                      sts,
	input  logic [bblur_pkg::FRAME_W_BITS-1:0]   frame_width,
	input  logic [bblur_pkg::FRAME_H_BITS-1:0]   frame_height,
	input  logic                                 func,
	input  logic [bblur_pkg::CH_BITS-1:0]        in_red,
	input  logic [bblur_pkg::CH_BITS-1:0]        in_green,
	input  logic [bblur_pkg::CH_BITS-1:0]        in_blue,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [bblur_pkg::CH_BITS-1:0]        out_red,
	output logic [bblur_pkg::CH_BITS-1:0]        out_green,
	output logic [bblur_pkg::CH_BITS-1:0]        out_blue,
	output logic                                 frame_end
);

	import bblur_pkg::*;

	localparam int RING     = 2 * MAX_LINE_PIXELS + 9;
	localparam int SW       = $clog2(RING);
	localparam int PEND_MAX = MAX_LINE_PIXELS + 2;
	localparam int PW       = $clog2(PEND_MAX + 1);
	localparam int WW       = $clog2(MAX_LINE_PIXELS + 1);
	localparam int CW       = $clog2(MAX_LINE_PIXELS);
	localparam int FHW      = FRAME_H_BITS;
	localparam int CMPW     = (WW > FRAME_W_BITS) ? WW : FRAME_W_BITS;
	localparam int NW       = (PW > WW + 1) ? PW : WW + 1;

	logic [SW-1:0]         ws_q, center_q, center_d, raddr;
	logic [SW:0]           ctr_diff, ctr_fix;
	logic [PW-1:0]         pend_q;
	logic [FHW-1:0]        ro_q, h_eff;
	logic [CW-1:0]         co_q;
	logic [WW-1:0]         w_eff;
	logic [CMPW-1:0]       fw_x;
	logic [FHW:0]          ro_p1;
	logic [WW:0]           co_p1, w_x, co_x, need;
	logic                  row_nx, col_nx, row_ok, col_ok;
	logic signed [SW+1:0]  base, wv, roff, coff, t, ring_s;
	logic [SW+1:0]         t_fix;
	logic                  we, re, rd_s1;
	logic [PIX_BITS-1:0]   wdata, rdata;
	logic [CNT_W-1:0]      cnt_q;
	logic [RECIP_W-1:0]    rcp;
	logic [CH_BITS-1:0]    rd_ch  [3];
	logic [SUM_W-1:0]      acc_q  [3];
	logic [SUM_W-1:0]      rnd    [3];
	logic [PROD_W-1:0]     prod_s1 [3];
	logic [CH_BITS-1:0]    res_q  [3];
	logic                  fe_q, ov_q;

	// effective frame size: zero acts as one, width clamps to the line store
	always_comb begin
		fw_x = CMPW'(frame_width);
		priority if (fw_x == '0) begin
			w_eff = WW'(1);
		end else if (fw_x > CMPW'(MAX_LINE_PIXELS)) begin
			w_eff = WW'(MAX_LINE_PIXELS);
		end else begin
			w_eff = WW'(fw_x);
		end
		h_eff = (frame_height == '0) ? FHW'(1) : frame_height;
	end

	assign ro_p1  = {1'b0, ro_q} + (FHW+1)'(1);
	assign row_nx = ro_p1 < {1'b0, h_eff};
	assign w_x    = {1'b0, w_eff};
	assign co_x   = (WW+1)'(co_q);
	assign co_p1  = co_x + (WW+1)'(1);
	assign col_nx = co_p1 < w_x;

	// pixels that must follow the oldest pending one before it can be filtered
	assign need = (row_nx ? w_x : '0) + (col_nx ? (WW+1)'(1) : '0);

	assign sts.res_ready = (pend_q != '0) && ((NW'(pend_q) - NW'(1)) >= NW'(need));
	assign sts.out_free  = !ov_q || out_ready;

	// centre slot = oldest pending pixel
	always_comb begin
		ctr_diff = {1'b0, ws_q} - (SW+1)'(pend_q);
		ctr_fix  = ctr_diff[SW] ? ctr_diff + (SW+1)'(RING) : ctr_diff;
		center_d = ctr_fix[SW-1:0];
	end

	always_comb begin
		unique case (cmd.row_sel)
			SEL_BEFORE: row_ok = (ro_q != '0) && (ro_q <= h_eff);
			SEL_CENTRE: row_ok = ro_q < h_eff;
			SEL_AFTER:  row_ok = row_nx;
			default:    row_ok = 1'b0;
		endcase
		unique case (cmd.col_sel)
			SEL_BEFORE: col_ok = (co_q != '0) && (co_x <= w_x);
			SEL_CENTRE: col_ok = co_x < w_x;
			SEL_AFTER:  col_ok = col_nx;
			default:    col_ok = 1'b0;
		endcase
	end

	// neighbour slot = centre + row offset (one line) + column offset, modulo the ring
	always_comb begin
		base   = signed'({2'b00, center_q});
		wv     = signed'((SW+2)'(w_eff));
		ring_s = signed'((SW+2)'(RING));
		unique case (cmd.row_sel)
			SEL_BEFORE: roff = -wv;
			SEL_AFTER:  roff = wv;
			default:    roff = '0;
		endcase
		coff = signed'((SW+2)'(cmd.col_sel)) - signed'((SW+2)'(1));
		t    = base + roff + coff;
		priority if (t < 0) begin
			t_fix = unsigned'(t + ring_s);
		end else if (t >= ring_s) begin
			t_fix = unsigned'(t - ring_s);
		end else begin
			t_fix = unsigned'(t);
		end
		raddr = t_fix[SW-1:0];
	end

	assign we    = cmd.store && (func == FUNC_PIXEL);
	assign re    = cmd.rd && row_ok && col_ok;
	assign wdata = {in_red, in_green, in_blue};

	bblur_ram #(
		.WIDTH (PIX_BITS),
		.DEPTH (RING)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (ws_q),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_ch[0] = rdata[3*CH_BITS-1:2*CH_BITS];
	assign rd_ch[1] = rdata[2*CH_BITS-1:CH_BITS];
	assign rd_ch[2] = rdata[CH_BITS-1:0];

	assign rcp = recip(cnt_q);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = acc_q[i] + SUM_W'(cnt_q >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= '0;
			pend_q <= '0;
			ro_q   <= '0;
			co_q   <= '0;
			rd_s1  <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			rd_s1 <= re;
			if (we) begin
				ws_q <= (ws_q == SW'(RING - 1)) ? '0 : ws_q + SW'(1);
				if (pend_q < PW'(PEND_MAX)) begin
					pend_q <= pend_q + PW'(1);
				end
			end
			if (cmd.emit) begin
				pend_q <= pend_q - PW'(1);
				if (col_nx) begin
					co_q <= co_p1[CW-1:0];
				end else begin
					co_q <= '0;
					ro_q <= row_nx ? ro_p1[FHW-1:0] : '0;
				end
			end
			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			center_q <= center_d;
			cnt_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (re) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (rd_s1) begin
				for (int i = 0; i < 3; i++) begin
					acc_q[i] <= acc_q[i] + SUM_W'(rd_ch[i]);
				end
			end
		end
		if (cmd.divide) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= PROD_W'(rnd[i]) * PROD_W'(rcp);
			end
		end
		if (cmd.emit) begin
			for (int i = 0; i < 3; i++) begin
				res_q[i] <= prod_s1[i][RECIP_K+CH_BITS-1:RECIP_K];
			end
			fe_q <= (ro_q == h_eff - FHW'(1)) && (WW'(co_q) == w_eff - WW'(1));
		end
	end

	assign out_valid = ov_q;
	assign out_red   = res_q[0];
	assign out_green = res_q[1];
	assign out_blue  = res_q[2];
	assign frame_end = fe_q;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(PEND_MAX))
		else $error("pending count beyond its bound");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		ws_q < SW'(RING))
		else $error("write slot outside the ring");

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> pend_q != '0)
		else $error("result emitted with nothing pending");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		re |-> raddr < SW'(RING))
		else $error("neighbour read outside the ring");

endmodule

`default_nettype wire

[sv/box_blur_3x3_edge_clipped.sv]
// 3x3 edge-clipped box blur over a raster stream of RGB pixels. Each result is the
// half-up rounded mean of every channel over the in-frame 3x3 neighbours of one pixel
// (9, 6 or 4 of them at interior, edge and corner; fewer on one-pixel frames), given
// in raster order. A result appears once all its neighbours have arrived, so it lags
// the input by one row and one pixel; drain items (func = 1) push out the tail of a
// frame, and a new frame may follow without draining. frame_width (byte address 0)
// and frame_height (byte address 4) are to be set over APB only while the block is
// idle; the block does not enforce this. An item that yields a result has its nine
// neighbours fetched one per cycle through the single read port of the pixel
// history RAM (2*MAX_LINE_PIXELS+9 entries), followed by a reciprocal multiply and
// the hand-over to the output register, where a finished result waits while the
// next item is taken. No clearing pass is needed after reset.
`default_nettype none

module box_blur_3x3_edge_clipped #(
	parameter int MAX_LINE_PIXELS = bblur_pkg::MAX_LINE_PIXELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bblur_in_if.sink                       pixel,
	bblur_out_if.source                    result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bblur_pkg::APB_AW-1:0]   paddr,
	input  logic [bblur_pkg::APB_DW-1:0]   pwdata,
	output logic [bblur_pkg::APB_DW-1:0]   prdata,
	output logic                           pready
);

	import bblur_pkg::*;

	logic [FRAME_W_BITS-1:0] fw_q;
	logic [FRAME_H_BITS-1:0] fh_q;
	logic                    reg_idx;
	logic                    cfg_wr;
	logic                    pix_ready;
	cmd_t                    cmd;
	sts_t                    sts;

	assign reg_idx = paddr[APB_AW-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_W_BITS'(640);
			fh_q <= FRAME_H_BITS'(480);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  fw_q <= pwdata[FRAME_W_BITS-1:0];
				REG_FRAME_HEIGHT: fh_q <= pwdata[FRAME_H_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = APB_DW'(fw_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(fh_q);
		endcase
	end

	bblur_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pixel.valid),
		.pix_ready (pix_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign pixel.ready = pix_ready;

	bblur_dp #(
		.MAX_LINE_PIXELS (MAX_LINE_PIXELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.frame_width  (fw_q),
		.frame_height (fh_q),
		.func         (pixel.func),
		.in_red       (pixel.in_red),
		.in_green     (pixel.in_green),
		.in_blue      (pixel.in_blue),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_red      (result.out_red),
		.out_green    (result.out_green),
		.out_blue     (result.out_blue),
		.frame_end    (result.frame_end)
	);

endmodule

`default_nettype wire
